// ----- design/lrutc_pkg.sv -----
package lrutc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_DEL   = 3'd2;
    localparam logic [2:0] OP_PROBE = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] key;
        logic [23:0] entry_bytes;
        logic [31:0] descriptor;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_eviction;
        logic [63:0] result_key;
        logic [23:0] result_bytes;
        logic [31:0] result_descriptor;
        logic [31:0] total_bytes;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EVICT,
        ACT_INSERT,
        ACT_GET,
        ACT_DEL,
        ACT_CLEAR
    } t_act;

    typedef struct packed {
        logic       latch;
        logic       lookup;
        logic       emit;
        t_act       act;
        logic [1:0] status;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       key_zero;
        logic       size_zero;
        logic       hit;
        logic       over;
        logic       empty;
        logic       full;
    } t_stat;

endpackage

// ----- design/lrutc_ctrl.sv -----
module lrutc_ctrl
    import lrutc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.act    = ACT_NONE;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
                case (i_stat.opcode)
                    OP_ADD: begin
                        if (i_stat.key_zero || i_stat.size_zero || i_stat.hit) begin
                            o_cmd.status = ST_INVALID;
                        end else if (i_stat.over && !i_stat.empty) begin
                            // one eviction per cycle, re-check next cycle
                            o_cmd.act  = ACT_EVICT;
                            o_cmd.last = 1'b0;
                            n_state    = S_EXEC;
                        end else if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_INSERT;
                        end
                    end
                    OP_GET: begin
                        if (i_stat.key_zero) begin
                            o_cmd.status = ST_INVALID;
                        end else if (!i_stat.hit) begin
                            o_cmd.status = ST_MISS;
                        end else begin
                            o_cmd.act = ACT_GET;
                        end
                    end
                    OP_DEL: begin
                        if (i_stat.key_zero) begin
                            o_cmd.status = ST_INVALID;
                        end else if (!i_stat.hit) begin
                            o_cmd.status = ST_MISS;
                        end else begin
                            o_cmd.act = ACT_DEL;
                        end
                    end
                    OP_PROBE: begin
                        if (i_stat.key_zero) begin
                            o_cmd.status = ST_INVALID;
                        end else if (!i_stat.hit) begin
                            o_cmd.status = ST_MISS;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.act = ACT_CLEAR;
                    end
                    default: begin
                        o_cmd.status = ST_INVALID;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/lrutc_dp.sv -----
module lrutc_dp
    import lrutc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_res_valid,
    output t_res        o_res
);

    t_req               r_req;
    logic [31:0]        r_budget;
    logic [31:0]        r_held, n_held;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_hit_vec;
    logic [63:0]        r_key  [ENTRIES];
    logic [23:0]        r_size [ENTRIES];
    logic [31:0]        r_hdl  [ENTRIES];
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [IDX_W-1:0]   n_rank [ENTRIES];
    logic               r_res_valid;
    t_res               r_res, n_res;

    logic [ENTRIES-1:0] hit_vec, oldest_oh, free_oh, sel_oh;
    logic [23:0]        sel_size;
    logic [31:0]        sel_hdl;
    logic [63:0]        sel_key;
    logic [IDX_W-1:0]   sel_rank;
    logic [32:0]        want;
    logic [CNT_W-1:0]   cnt_m1;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]   = r_valid[i] && (r_key[i] == r_req.key);
            oldest_oh[i] = r_valid[i] && (r_rank[i] == '0);
        end
    end

    // lowest free slot, one-hot
    assign free_oh = ~r_valid & (r_valid + ENTRIES'(1));
    assign sel_oh  = (i_cmd.act == ACT_EVICT) ? oldest_oh : r_hit_vec;

    always_comb begin
        sel_key  = '0;
        sel_size = '0;
        sel_hdl  = '0;
        sel_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_oh[i]) begin
                sel_key  = sel_key  | r_key[i];
                sel_size = sel_size | r_size[i];
                sel_hdl  = sel_hdl  | r_hdl[i];
                sel_rank = sel_rank | r_rank[i];
            end
        end
    end

    assign want   = {1'b0, r_held} + {9'd0, r_req.entry_bytes};
    assign cnt_m1 = r_count - CNT_W'(1);

    always_comb begin
        o_stat.opcode    = r_req.opcode;
        o_stat.key_zero  = (r_req.key == '0);
        o_stat.size_zero = (r_req.entry_bytes == '0);
        o_stat.hit       = |r_hit_vec;
        o_stat.over      = (r_budget != '0) && (want > {1'b0, r_budget});
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == CNT_W'(ENTRIES));
    end

    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_valid = r_valid;
        n_rank  = r_rank;
        case (i_cmd.act)
            ACT_EVICT, ACT_DEL: begin
                n_held  = r_held - {8'd0, sel_size};
                n_count = cnt_m1;
                n_valid = r_valid & ~sel_oh;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && r_rank[i] > sel_rank) begin
                        n_rank[i] = r_rank[i] - IDX_W'(1);
                    end
                end
            end
            ACT_INSERT: begin
                n_held  = r_held + {8'd0, r_req.entry_bytes};
                n_count = r_count + CNT_W'(1);
                n_valid = r_valid | free_oh;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_oh[i]) begin
                        n_rank[i] = r_count[IDX_W-1:0];
                    end
                end
            end
            ACT_GET: begin
                if (r_budget != '0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (sel_oh[i]) begin
                            n_rank[i] = cnt_m1[IDX_W-1:0];
                        end else if (r_valid[i] && r_rank[i] > sel_rank) begin
                            n_rank[i] = r_rank[i] - IDX_W'(1);
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                n_held  = '0;
                n_count = '0;
                n_valid = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_res                   = '0;
        n_res.status            = i_cmd.status;
        n_res.last              = i_cmd.last;
        n_res.total_bytes       = n_held;
        n_res.result_key        = r_req.key;
        if (i_cmd.act == ACT_EVICT) begin
            n_res.is_eviction       = 1'b1;
            n_res.result_key        = sel_key;
            n_res.result_bytes      = sel_size;
            n_res.result_descriptor = sel_hdl;
        end else if (i_cmd.act == ACT_GET) begin
            n_res.result_bytes      = sel_size;
            n_res.result_descriptor = sel_hdl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= '0;
            r_held      <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            r_held      <= n_held;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_res_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_hit_vec <= hit_vec;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
        r_rank <= n_rank;
        if (i_cmd.act == ACT_INSERT) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (free_oh[i]) begin
                    r_key[i]  <= r_req.key;
                    r_size[i] <= r_req.entry_bytes;
                    r_hdl[i]  <= r_req.descriptor;
                end
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- design/size_budgeted_lru_tag_cache.sv -----
// A request is latched in S_IDLE, its hit vector is registered in S_LOOK and
// the final result word is registered in S_EXEC; each evicted entry comes out
// as its own word ahead of it, from a repeated pass through S_EXEC.
// Start is taken only in S_IDLE, so a new item waits for the final word; the
// lookup register and the one-eviction-per-cycle loop in the controller keep busy high.
// Reset (synchronous, active low) empties the table, zeroes held bytes and
// budget. Result words are strobed for one cycle; the receiver cannot stall.
module size_budgeted_lru_tag_cache
    import lrutc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_res_valid,
    output t_res        o_res
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lrutc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lrutc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
